### sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/hpd_pkg.sv
// Types and constants of the Hill pair decipher.
`default_nettype none
package hpd_pkg;

  localparam logic [63:0] FNV_BASIS   = 64'hcbf29ce484222325;
  localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;   // prime is 2^40 + this
  localparam int          FNV_PRIME_SHIFT = 40;
  localparam logic [63:0] KEY_XOR     = 64'hdeadbeefcafebabe;
  // Only the low byte of each mixing/LCG step reaches a matrix byte.
  localparam logic [7:0]  MIX_MUL_LO  = 8'h2d;
  localparam logic [7:0]  MIX_ADD_LO  = 8'h7c;
  localparam logic [7:0]  LCG_MUL_LO  = 8'h2d;
  localparam logic [7:0]  LCG_ADD_LO  = 8'h4f;

  typedef struct packed {
    logic [63:0]     whiten;
    logic [3:0][7:0] mat;
    logic [7:0]      det_inv;
  } hpd_key_t;

endpackage
`default_nettype wire

### sv/hpd_keygen.sv
// Key derivation sequencer: FNV-1a hash, LCG matrix bytes, determinant inverse.
`default_nettype none
module hpd_keygen (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [63:0]       cfg_wr_data,
  output logic                   key_ready,
  output hpd_pkg::hpd_key_t      key
);

  localparam logic [2:0] ST_HASH  = 3'd0;
  localparam logic [2:0] ST_LCG   = 3'd1;
  localparam logic [2:0] ST_PROD  = 3'd2;
  localparam logic [2:0] ST_DET   = 3'd3;
  localparam logic [2:0] ST_INV   = 3'd4;
  localparam logic [2:0] ST_READY = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [63:0]       ts_r, ts_nxt;
  logic [63:0]       h_r, h_nxt;
  logic [7:0]        lcg_r, lcg_nxt;
  logic [15:0]       p03_r, p03_nxt;
  logic [15:0]       p12_r, p12_nxt;
  logic [7:0]        det_r, det_nxt;
  logic [7:0]        inv_r, inv_nxt;
  logic [7:0]        tmp_r, tmp_nxt;
  hpd_pkg::hpd_key_t key_r, key_nxt;

  logic [63:0] hx;
  logic [63:0] h_step;
  logic        prod_eq;
  logic [7:0]  m0_fix;

  assign hx     = h_r ^ {56'd0, ts_r[{cnt_r, 3'b000} +: 8]};
  assign h_step = (hx << hpd_pkg::FNV_PRIME_SHIFT) + hx * {55'd0, hpd_pkg::FNV_PRIME_LO};
  assign prod_eq = (p03_r == p12_r);
  assign m0_fix  = prod_eq ? 8'(key_r.mat[0] + 8'd2) : key_r.mat[0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ts_nxt    = ts_r;
    h_nxt     = h_r;
    lcg_nxt   = lcg_r;
    p03_nxt   = p03_r;
    p12_nxt   = p12_r;
    det_nxt   = det_r;
    inv_nxt   = inv_r;
    tmp_nxt   = tmp_r;
    key_nxt   = key_r;
    if (cfg_wr_en) begin
      // restart derivation from the new time value
      ts_nxt    = cfg_wr_data;
      h_nxt     = hpd_pkg::FNV_BASIS;
      cnt_nxt   = 3'd0;
      state_nxt = ST_HASH;
    end else begin
      unique case (state_r)
        ST_HASH: begin
          h_nxt   = h_step;
          cnt_nxt = 3'(cnt_r + 3'd1);
          if (cnt_r == 3'd7) begin
            key_nxt.whiten = h_step ^ hpd_pkg::KEY_XOR;
            state_nxt      = ST_LCG;
          end
        end
        ST_LCG: begin
          if (cnt_r == 3'd0) begin
            lcg_nxt = 8'(key_r.whiten[7:0] * hpd_pkg::MIX_MUL_LO + hpd_pkg::MIX_ADD_LO);
          end else begin
            lcg_nxt = 8'(lcg_r * hpd_pkg::LCG_MUL_LO + hpd_pkg::LCG_ADD_LO);
          end
          key_nxt.mat[cnt_r[1:0]] = lcg_nxt;
          // corner bytes are forced odd
          if (cnt_r == 3'd0 || cnt_r == 3'd3) begin
            key_nxt.mat[cnt_r[1:0]] = lcg_nxt | 8'd1;
          end
          cnt_nxt = 3'(cnt_r + 3'd1);
          if (cnt_r == 3'd3) begin
            state_nxt = ST_PROD;
          end
        end
        ST_PROD: begin
          p03_nxt   = {8'd0, key_r.mat[0]} * {8'd0, key_r.mat[3]};
          p12_nxt   = {8'd0, key_r.mat[1]} * {8'd0, key_r.mat[2]};
          state_nxt = ST_DET;
        end
        ST_DET: begin
          // exact zero determinant: bump the first byte by two
          key_nxt.mat[0] = m0_fix;
          if (prod_eq) begin
            det_nxt = 8'(m0_fix * key_r.mat[3] - p12_r[7:0]);
          end else begin
            det_nxt = 8'(p03_r[7:0] - p12_r[7:0]);
          end
          inv_nxt   = det_nxt;
          cnt_nxt   = 3'd0;
          state_nxt = ST_INV;
        end
        ST_INV: begin
          // Newton step split in two: t = 2 - d*inv, then inv = inv*t
          if (!cnt_r[0]) begin
            tmp_nxt = 8'(8'd2 - 8'(det_r * inv_r));
          end else begin
            inv_nxt = 8'(inv_r * tmp_r);
          end
          cnt_nxt = 3'(cnt_r + 3'd1);
          if (cnt_r == 3'd5) begin
            key_nxt.det_inv = det_r[0] ? inv_nxt : 8'd1;
            state_nxt       = ST_READY;
          end
        end
        ST_READY: begin
          state_nxt = ST_READY;
        end
        default: begin
          state_nxt = ST_HASH;
          cnt_nxt   = 3'd0;
          h_nxt     = hpd_pkg::FNV_BASIS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HASH;
      cnt_r   <= 3'd0;
      ts_r    <= 64'd0;
      h_r     <= hpd_pkg::FNV_BASIS;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ts_r    <= ts_nxt;
      h_r     <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lcg_r <= lcg_nxt;
    p03_r <= p03_nxt;
    p12_r <= p12_nxt;
    det_r <= det_nxt;
    inv_r <= inv_nxt;
    tmp_r <= tmp_nxt;
    key_r <= key_nxt;
  end

  assign key_ready = (state_r == ST_READY);
  assign key       = key_r;

endmodule
`default_nettype wire

### sv/hpd_datapath.sv
// Three-stage decipher pipeline: whiten, cross products, scale by inverse.
`default_nettype none
module hpd_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hpd_pkg::hpd_key_t key,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        cipher_even,
  input  wire logic [7:0]        cipher_odd,
  input  wire logic [1:0]        pair_slot,
  input  wire logic              last_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             plain_even,
  output logic [7:0]             plain_odd,
  output logic                   last_out
);

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  logic [7:0] a_r, b_r;
  logic       l1_r, l2_r, l3_r;
  logic [7:0] p0_r, p1_r, p2_r, p3_r;
  logic [7:0] x_r, y_r;

  logic [63:0] wsh;

  // a stage moves when it is empty or its successor moves
  assign rdy3 = !v3_r || out_ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign wsh = key.whiten >> {pair_slot, 4'b0000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      a_r  <= cipher_even ^ wsh[7:0];
      b_r  <= cipher_odd ^ wsh[15:8];
      l1_r <= last_in;
    end
    if (rdy2 && v1_r) begin
      p0_r <= 8'(a_r * key.mat[3]);
      p1_r <= 8'(key.mat[1] * b_r);
      p2_r <= 8'(key.mat[0] * b_r);
      p3_r <= 8'(a_r * key.mat[2]);
      l2_r <= l1_r;
    end
    if (rdy3 && v2_r) begin
      x_r  <= 8'(8'(p0_r - p1_r) * key.det_inv);
      y_r  <= 8'(8'(p2_r - p3_r) * key.det_inv);
      l3_r <= l2_r;
    end
  end

  assign out_valid  = v3_r;
  assign plain_even = x_r;
  assign plain_odd  = y_r;
  assign last_out   = l3_r;

endmodule
`default_nettype wire

### sv/hill_pair_decipher.sv
// Top level of the Hill pair decipher: key sequencer and decipher pipeline.
//
// Usage:
//   in_*  : ciphertext byte pairs. tdata = {cipher_odd, cipher_even},
//           tuser = pair_slot (picks whitening bytes 2*slot, 2*slot+1),
//           tlast marks the final pair of a message.
//   out_* : plaintext byte pairs. tdata = {plain_odd, plain_even},
//           tlast copies the input marker.
//   cfg_* : write the 64-bit timestamp; the whole key is re-derived.
// Key derivation runs after reset or after a timestamp write:
//   8 hash rounds (one FNV-1a byte per cycle), 4 LCG steps, the cross
//   products, the determinant and its zero fix, then the Newton inverse.
//   in_tready stays low during that time.
// Once ready, one pair is taken per cycle unless a held out_tready has
//   filled the pipeline. An accepted pair passes three register stages
//   (whiten, cross products, scale by inverse) before out_tvalid shows it.
// When out_tready is low the pipeline fills and holds; in_tready drops
//   only once all three stages hold an item, and nothing is dropped.
// Reset (rst_n low, synchronous) empties the pipeline and restarts the
//   key derivation from a zero timestamp.
`default_nettype none
module hill_pair_decipher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // slave side
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] cipher_even, [15:8] cipher_odd
  input  wire logic [1:0]  in_tuser,   // [1:0] pair_slot
  input  wire logic        in_tlast,   // last_in
  // master side
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] plain_even, [15:8] plain_odd
  output logic             out_tlast,  // last_out
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [63:0] cfg_wr_data // timestamp
);

  hpd_pkg::hpd_key_t key;
  logic              key_ready;
  logic              dp_in_valid;
  logic              dp_in_ready;

  hpd_keygen u_keygen (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .key_ready   (key_ready),
    .key         (key)
  );

  // hold off input until the key is settled
  assign dp_in_valid = in_tvalid && key_ready;
  assign in_tready   = dp_in_ready && key_ready;

  hpd_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .key         (key),
    .in_valid    (dp_in_valid),
    .in_ready    (dp_in_ready),
    .cipher_even (in_tdata[7:0]),
    .cipher_odd  (in_tdata[15:8]),
    .pair_slot   (in_tuser),
    .last_in     (in_tlast),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .plain_even  (out_tdata[7:0]),
    .plain_odd   (out_tdata[15:8]),
    .last_out    (out_tlast)
  );

endmodule
`default_nettype wire

### sv/hpd_checker.sv
// Port-level checker for the Hill pair decipher, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module hpd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        cfg_wr_en
);

  // a timestamp write starts a derivation, so input must close next cycle
  `ASSERT_NXT(a_cfg_blocks_input, cfg_wr_en, !in_tready)
  // leaving reset: key not derived and pipeline empty
  `ASSERT_IMP(a_reset_state, $past(!rst_n), !in_tready && !out_tvalid)
  // stalled result holds its value
  `ASSERT_NXT(a_out_hold, out_tvalid && !out_tready,
              out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  // a result leaves only by a handshake
  `ASSERT_IMP(a_out_drop, $fell(out_tvalid), $past(out_tready))

endmodule

bind hill_pair_decipher hpd_checker u_hpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_wr_en  (cfg_wr_en)
);
`default_nettype wire

### dv/plain_check_pkg.sv
// Expected-plaintext tracker for the Hill pair decipher testbench.
package plain_check_pkg;

  localparam bit [63:0] HASH_BASIS   = 64'hcbf29ce484222325;
  localparam bit [63:0] HASH_PRIME   = 64'h00000100000001b3;
  localparam bit [63:0] WHITEN_XOR   = 64'hdeadbeefcafebabe;
  localparam bit [63:0] SPREAD_MUL   = 64'h5851f42d4c957f2d;
  localparam bit [63:0] SPREAD_ADD   = 64'h6c576fac43fd007c;
  localparam bit [63:0] CHAIN_MUL    = 64'h000000004c957f2d;
  localparam bit [63:0] CHAIN_ADD    = 64'h00000000f767814f;
  localparam bit [63:0] SEARCH_SPAN  = 64'd1048576;

  typedef struct {
    bit [7:0] even;
    bit [7:0] odd;
    bit       last;
  } plain_pair_t;

  typedef enum {KEY_ZERO_FIX, KEY_EVEN_DET, KEY_ODD_DET} key_case_t;

  class plaintext_tracker;
    bit [63:0]   whiten;
    bit [7:0]    mat [4];
    bit [7:0]    det_inv;
    bit          zero_fixed;
    bit          det_odd;
    plain_pair_t plain_due [$];
    int unsigned mismatches;

    // Rebuild whitening key, matrix and determinant inverse from a timestamp.
    function void load_timestamp(bit [63:0] ts);
      bit [63:0]   h;
      bit [63:0]   v;
      bit [63:0]   r;
      bit [7:0]    det;
      bit [7:0]    cand;
      bit [7:0]    prod;
      int unsigned p;
      int unsigned q;
      int          i;
      h = HASH_BASIS;
      for (i = 0; i < 8; i++) begin
        h = h ^ {56'd0, ts[8*i +: 8]};
        h = h * HASH_PRIME;
      end
      whiten = h ^ WHITEN_XOR;
      v = whiten * SPREAD_MUL + SPREAD_ADD;
      mat[0] = v[7:0] | 8'h01;
      r = v * CHAIN_MUL + CHAIN_ADD;
      mat[1] = r[7:0];
      r = r * CHAIN_MUL + CHAIN_ADD;
      mat[2] = r[7:0];
      r = r * CHAIN_MUL + CHAIN_ADD;
      mat[3] = r[7:0] | 8'h01;
      // exact products, not mod 256
      p = mat[0] * mat[3];
      q = mat[1] * mat[2];
      zero_fixed = (p == q);
      if (zero_fixed) mat[0] = mat[0] + 8'd2;
      det = mat[0] * mat[3] - mat[1] * mat[2];
      det_odd = det[0];
      det_inv = 8'd1;
      if (det_odd) begin
        for (i = 1; i < 256; i += 2) begin
          cand = i[7:0];
          prod = det * cand;
          if (prod == 8'd1) det_inv = cand;
        end
      end
    endfunction

    // Scan small timestamps for one that hits the wanted key case; 0 if none.
    function bit [63:0] find_timestamp(key_case_t want);
      bit [63:0] ts;
      bit        hit;
      ts = 64'd0;
      hit = 1'b0;
      while (!hit && ts < SEARCH_SPAN) begin
        ts++;
        load_timestamp(ts);
        case (want)
          KEY_ZERO_FIX: hit = zero_fixed;
          KEY_EVEN_DET: hit = !det_odd;
          default:      hit = det_odd;
        endcase
      end
      return hit ? ts : 64'd0;
    endfunction

    function void note_cipher(bit [7:0] even, bit [7:0] odd, bit [1:0] slot, bit last);
      bit [7:0]    a;
      bit [7:0]    b;
      plain_pair_t exp_pair;
      a = even ^ whiten[16*slot +: 8];
      b = odd ^ whiten[16*slot + 8 +: 8];
      exp_pair.even = a * mat[3] - mat[1] * b;
      exp_pair.even = exp_pair.even * det_inv;
      exp_pair.odd  = mat[0] * b - a * mat[2];
      exp_pair.odd  = exp_pair.odd * det_inv;
      exp_pair.last = last;
      plain_due.push_back(exp_pair);
    endfunction

    function void check_plain(bit [7:0] even, bit [7:0] odd, bit last);
      plain_pair_t exp_pair;
      if (plain_due.size() == 0) begin
        $error("unexpected result: plain_even %0h plain_odd %0h last_out %0b",
               even, odd, last);
        mismatches++;
        return;
      end
      exp_pair = plain_due.pop_front();
      if (even != exp_pair.even) begin
        $error("plain_even: expected %0h, actual %0h", exp_pair.even, even);
        mismatches++;
      end
      if (odd != exp_pair.odd) begin
        $error("plain_odd: expected %0h, actual %0h", exp_pair.odd, odd);
        mismatches++;
      end
      if (last != exp_pair.last) begin
        $error("last_out: expected %0b, actual %0b", exp_pair.last, last);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return plain_due.size();
    endfunction
  endclass

endpackage

### dv/tb_top.sv
// Top-level testbench of the Hill pair decipher: stimulus, checking and watchdog.
module tb_top;

  // Cycles without any handshake or write before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 1000;
  // Tail after the last result: pipeline depth plus margin.
  localparam int unsigned TAIL_CYCLES = 10;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] cipher_even, [15:8] cipher_odd
  logic [1:0]  in_tuser;   // [1:0] pair_slot
  logic        in_tlast;   // last_in
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [7:0] plain_even, [15:8] plain_odd
  logic        out_tlast;  // last_out
  logic        cfg_wr_en;
  logic [63:0] cfg_wr_data;

  plain_check_pkg::plaintext_tracker plain_sb;
  int unsigned      quiet_cycles;
  int unsigned      cycle_no;
  int unsigned      stall_mode;
  int unsigned      burst_left;
  bit [63:0]        ts_zero_fix;
  bit [63:0]        ts_even_det;
  bit [63:0]        ts_odd_det;

  hill_pair_decipher uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver, result check and watchdog. Handshake signals read here hold
  // their pre-edge values, since every driver updates them by NBA.
  always @(posedge clk) begin
    cycle_no++;
    // Pick a new stall pattern at regular intervals.
    if (cycle_no % 150 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 1) == 0);
      2:       out_tready <= (cycle_no % 11 < 3);
      default: out_tready <= ($urandom_range(0, 7) != 0);
    endcase

    if (rst_n && out_tvalid && out_tready)
      plain_sb.check_plain(out_tdata[7:0], out_tdata[15:8], out_tlast);

    if (!rst_n || cfg_wr_en || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one pair and hold it until the block takes it.
  task automatic send_pair(bit [7:0] even, bit [7:0] odd, bit [1:0] slot, bit last);
    in_tvalid <= 1'b1;
    in_tdata  <= {odd, even};
    in_tuser  <= slot;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    plain_sb.note_cipher(even, odd, slot, last);
  endtask

  // Drop valid and idle for the given pause; zero keeps the stream back to back.
  task automatic pause_sender(int unsigned n);
    if (n == 0) return;
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Advance the burst pattern: at the end of a burst, idle and pick a new length.
  task automatic burst_gap();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
    end
    burst_left--;
  endtask

  // Hold the sender until every expected result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (plain_sb.pending() != 0);
  endtask

  // Write the timestamp on an idle block and re-key the predictor.
  task automatic write_timestamp(bit [63:0] ts);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ts;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    plain_sb.load_timestamp(ts);
  endtask

  // Well-formed message: slots count up mod 4, last on the final pair,
  // final odd byte zeroed as padding about half the time.
  task automatic send_message(int unsigned len);
    bit pad;
    int unsigned p;
    pad = 1'($urandom_range(0, 1));
    for (p = 0; p < len; p++) begin
      burst_gap();
      send_pair(8'($urandom_range(0, 255)),
                (p == len - 1 && pad) ? 8'd0 : 8'($urandom_range(0, 255)),
                p[1:0], p == len - 1);
    end
  endtask

  // Mostly messages, some noise with arbitrary slot/last, and an odd full drain.
  task automatic run_traffic(int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    int unsigned k;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        len = $urandom_range(1, 12);
        send_message(len);
        sent += len;
      end else if (pick == 8 || $urandom_range(0, 2) != 0) begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) begin
          burst_gap();
          send_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
        sent += len;
      end else begin
        drain_results();
      end
    end
  endtask

  initial begin
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    in_tlast    <= 1'b0;
    out_tready  <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    rst_n       <= 1'b0;
    quiet_cycles = 0;
    cycle_no     = 0;
    stall_mode   = 0;
    burst_left   = 0;

    // Find timestamps for the key corner cases before time advances.
    plain_sb    = new();
    ts_zero_fix = plain_sb.find_timestamp(plain_check_pkg::KEY_ZERO_FIX);
    ts_even_det = plain_sb.find_timestamp(plain_check_pkg::KEY_EVEN_DET);
    ts_odd_det  = plain_sb.find_timestamp(plain_check_pkg::KEY_ODD_DET);
    plain_sb.load_timestamp(64'd0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset key, byte extremes on every slot, padded last pair.
    send_pair(8'h00, 8'h00, 2'd0, 1'b0);
    send_pair(8'hff, 8'hff, 2'd1, 1'b0);
    send_pair(8'hff, 8'h00, 2'd2, 1'b0);
    send_pair(8'h00, 8'hff, 2'd3, 1'b1);
    send_pair(8'hff, 8'hff, 2'd0, 1'b1);
    send_pair(8'ha5, 8'h00, 2'd1, 1'b1);
    send_pair(8'h5a, 8'hc3, 2'd3, 1'b0);
    send_pair(8'h01, 8'h80, 2'd2, 1'b1);

    // Directed: key needing the zero-determinant fix, then one with no inverse.
    write_timestamp(ts_zero_fix);
    send_pair(8'h00, 8'hff, 2'd0, 1'b0);
    send_pair(8'hff, 8'h00, 2'd1, 1'b0);
    send_pair(8'h3c, 8'h96, 2'd2, 1'b0);
    send_pair(8'hff, 8'h00, 2'd3, 1'b1);
    write_timestamp(ts_even_det);
    send_pair(8'h12, 8'h34, 2'd0, 1'b0);
    send_pair(8'hff, 8'hff, 2'd1, 1'b0);
    send_pair(8'h00, 8'h00, 2'd2, 1'b0);
    send_pair(8'h7f, 8'h00, 2'd3, 1'b1);

    // Random traffic over a spread of keys, extremes included.
    write_timestamp(64'hffff_ffff_ffff_ffff);
    run_traffic(125);
    write_timestamp(ts_odd_det);
    run_traffic(125);
    write_timestamp({$urandom, $urandom});
    run_traffic(125);
    write_timestamp(64'd0);
    run_traffic(125);
    write_timestamp({$urandom, $urandom});
    run_traffic(125);
    write_timestamp(ts_even_det);
    run_traffic(125);
    write_timestamp({$urandom, $urandom});
    run_traffic(125);
    write_timestamp(ts_zero_fix);
    run_traffic(125);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (plain_sb.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
